### sv/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Longest search / replacement pattern in bytes, also the window depth
  localparam int MAX_PATTERN = 16;
  // Bits that index one window position
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  // Width of the pattern length register
  localparam int LEN_W       = 5;
  // Default width of the running stream offset
  localparam int OFFSET_BITS = 32;
  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  // Configuration port widths
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_HIGH = 3'd4;

  // Input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } spr_in_t;

  // Result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] out_offset;
    logic        match_start;
    logic        out_last;
    logic [31:0] match_total;
  } spr_out_t;

  // Emit command: send bytes[first_idx..stop_idx] in order
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic [IDX_W-1:0]            first_idx;
    logic [IDX_W-1:0]            stop_idx;
    logic                        hit;
    logic [IDX_W-1:0]            match_pos;
    logic                        last;
  } spr_cmd_t;

endpackage

### sv/spr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_front
// Accepts bytes, keeps the pending window and configuration, runs the window
// compare and issues one emit command per item that fills it or ends a stream.
// ----------------------------------------------------------------------------
module spr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spr_pkg::spr_in_t                 in_item,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // command queue
  input  logic                             q_full,
  output logic                             push,
  output spr_pkg::spr_cmd_t                cmd
);

  localparam int MAXP  = spr_pkg::MAX_PATTERN;
  localparam int IDX_W = spr_pkg::IDX_W;
  localparam int LEN_W = spr_pkg::LEN_W;

  logic [LEN_W-1:0]                len_cfg_r;
  logic [spr_pkg::CFG_DATA_W-1:0]  search_low_r, search_high_r;
  logic [spr_pkg::CFG_DATA_W-1:0]  replace_low_r, replace_high_r;

  logic [MAXP-1:0][7:0]            win_r, win_new;
  logic [IDX_W-1:0]                cnt_r, cnt_nxt;

  logic [MAXP-1:0][7:0]            srch, repl;
  logic [LEN_W-1:0]                len_eff;
  logic [LEN_W-1:0]                cnt_inc;
  logic                            accept, win_full, hit;
  logic [MAXP-1:0]                 in_pat, eq;
  logic [MAXP-1:0][IDX_W-1:0]      pidx;
  logic [LEN_W:0]                  pos_sum [MAXP];
  logic [IDX_W-1:0]                tail_pos;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r      <= LEN_W'(1);
      search_low_r   <= '0;
      search_high_r  <= '0;
      replace_low_r  <= '0;
      replace_high_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spr_pkg::CFG_LENGTH:       len_cfg_r      <= cfg_data[LEN_W-1:0];
        spr_pkg::CFG_SEARCH_LOW:   search_low_r   <= cfg_data;
        spr_pkg::CFG_SEARCH_HIGH:  search_high_r  <= cfg_data;
        spr_pkg::CFG_REPLACE_LOW:  replace_low_r  <= cfg_data;
        spr_pkg::CFG_REPLACE_HIGH: replace_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign srch = {search_high_r, search_low_r};
  assign repl = {replace_high_r, replace_low_r};

  // clamp the length to 1..MAXP
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_cfg_r > LEN_W'(MAXP)) begin
      len_eff = LEN_W'(MAXP);
    end else begin
      len_eff = len_cfg_r;
    end
  end

  // window after the new byte: oldest toward position 0, newest at the top
  always_comb begin
    for (int p = 0; p < MAXP - 1; p++) begin
      win_new[p] = win_r[p+1];
    end
    win_new[MAXP-1] = in_item.in_byte;
  end

  assign cnt_inc  = LEN_W'(cnt_r) + LEN_W'(1);
  assign win_full = cnt_inc >= len_eff;
  // first position of the pattern in the window
  assign tail_pos = IDX_W'(LEN_W'(MAXP) - len_eff);

  // pattern aligned to the newest end of the window, compared in parallel
  always_comb begin
    for (int p = 0; p < MAXP; p++) begin
      pos_sum[p] = (LEN_W+1)'(p) + (LEN_W+1)'(len_eff);
      in_pat[p]  = pos_sum[p] >= (LEN_W+1)'(MAXP);
      pidx[p]    = IDX_W'(pos_sum[p] - (LEN_W+1)'(MAXP));
      eq[p]      = !in_pat[p] || (win_new[p] == srch[pidx[p]]);
    end
  end

  assign hit = win_full && (&eq);

  // emit command
  always_comb begin
    for (int p = 0; p < MAXP; p++) begin
      cmd.bytes[p] = (hit && in_pat[p]) ? repl[pidx[p]] : win_new[p];
    end
    cmd.first_idx = IDX_W'(MAXP - 1) - cnt_r;
    cmd.stop_idx  = (hit || in_item.in_last) ? IDX_W'(MAXP - 1) : tail_pos;
    cmd.hit       = hit;
    cmd.match_pos = tail_pos;
    cmd.last      = in_item.in_last;
  end

  assign push = accept && (win_full || in_item.in_last);

  // pending count
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_item.in_last || hit) begin
        cnt_nxt = '0;
      end else if (win_full) begin
        cnt_nxt = IDX_W'(len_eff - LEN_W'(1));
      end else begin
        cnt_nxt = IDX_W'(cnt_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_new;
    end
  end

endmodule

### sv/spr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_queue
// Short first-in first-out queue of emit commands between front and back.
// ----------------------------------------------------------------------------
module spr_queue #(
  parameter int DEPTH = spr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spr_pkg::spr_cmd_t cmd_in,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output spr_pkg::spr_cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spr_pkg::spr_cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### sv/spr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_back
// Walks each emit command one byte per cycle unless out_stall holds it,
// numbers bytes, keeps the match count, drives the registered result channel.
// ----------------------------------------------------------------------------
module spr_back #(
  parameter int OFFSET_BITS = spr_pkg::OFFSET_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // command queue head
  input  logic              head_valid,
  input  spr_pkg::spr_cmd_t head,
  output logic              pop,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output spr_pkg::spr_out_t out_item
);

  localparam int IDX_W = spr_pkg::IDX_W;

  logic                     started_r, started_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]   ofs_r, ofs_nxt;
  logic [31:0]              total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  spr_pkg::spr_out_t        out_item_r;

  logic [IDX_W-1:0]         cur_pos;
  logic                     load, at_stop, is_start, is_last;
  logic [31:0]              total_cur;

  assign cur_pos   = started_r ? pos_r : head.first_idx;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign at_stop   = cur_pos == head.stop_idx;
  assign is_start  = head.hit && (cur_pos == head.match_pos);
  assign is_last   = head.last && at_stop;
  // saturating count, bumped on the first byte of a replacement
  assign total_cur = (is_start && (total_r != '1)) ? total_r + 32'd1 : total_r;
  assign pop       = load && at_stop;

  always_comb begin
    started_nxt   = started_r;
    pos_nxt       = pos_r;
    ofs_nxt       = ofs_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      started_nxt   = !at_stop;
      pos_nxt       = cur_pos + IDX_W'(1);
      ofs_nxt       = is_last ? '0 : ofs_r + OFFSET_BITS'(1);
      total_nxt     = is_last ? '0 : total_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      pos_r       <= '0;
      ofs_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      pos_r       <= pos_nxt;
      ofs_r       <= ofs_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.out_byte    <= head.bytes[cur_pos];
      out_item_r.out_offset  <= 32'(ofs_r);
      out_item_r.match_start <= is_start;
      out_item_r.out_last    <= is_last;
      out_item_r.match_total <= total_cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/stream_pattern_replace_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_replace_top
// Byte stream find-and-replace with offsets, match marks and a match count.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle while the command queue is not
// full; the front compares the whole window against the search pattern
// combinationally and queues one emit command per item that fills the
// window or ends the stream, and the back sends one result byte per cycle
// while out_stall is low. The first result of an item passes through the
// command queue and then the output register. A matched occurrence of length
// L leaves as L bytes, while the L items that formed it gave no result, so a
// stream flows at one byte per cycle in and out while nothing stalls. Its
// final item (a window flush) or the first item after the length is lowered
// can send up to a window of bytes; the input stalls while the queue is full.
// No clearing pass follows reset. The user must write configuration while the
// block is idle; the block does not enforce this. cfg_ready is always high.
module stream_pattern_replace_top #(
  parameter int OFFSET_BITS = spr_pkg::OFFSET_BITS,
  parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spr_pkg::spr_in_t                 in_item,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output spr_pkg::spr_out_t                out_item,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic              q_full, push, pop, head_valid;
  spr_pkg::spr_cmd_t cmd, head;

  // classify items, hold window and configuration
  spr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (cmd)
  );

  // command queue
  spr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .cmd_in     (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // emit bytes
  spr_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef ASSERT_OFF
  // a queued command always walks forward through the window
  a_cmd_order: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cmd.first_idx <= cmd.stop_idx))
    else $error("emit command range runs backward");

  // a replacement ends at the newest window position, inside the range
  a_hit_span: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.hit) |->
      (cmd.stop_idx == spr_pkg::IDX_W'(spr_pkg::MAX_PATTERN - 1)) &&
      (cmd.match_pos >= cmd.first_idx))
    else $error("replacement outside emit range");

  // the back never retires a command that is not there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty command queue");

  // a replaced occurrence is always counted
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.match_start) |-> (out_item.match_total != 32'd0))
    else $error("match start with zero match count");
`endif

endmodule
